// ===== src/fpgs_pkg.sv =====
package fpgs_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam int SEED_W   = 48;
	localparam int HALF_W   = 24;
	localparam int PIX_W    = 32;
	localparam int PERM_W   = 6;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CMD_W    = 2;
	localparam int POS_W    = 6;
	localparam int PICK_SHIFT = 7;

	localparam logic [35:0]       LCG_MUL     = 36'h5DEECE66D;
	localparam logic [HALF_W-1:0] LCG_MUL_LO  = LCG_MUL[HALF_W-1:0];
	localparam logic [HALF_W-1:0] LCG_MUL_HI  = {12'd0, LCG_MUL[35:HALF_W]};
	localparam logic [SEED_W-1:0] LCG_ADD     = 48'hB;
	localparam logic [SEED_W-1:0] SEED_XOR    = 48'hA0DE23AC904C;
	localparam logic [PIX_W-1:0]  BORDER_GREY = 32'hFF444444;

	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

endpackage

// ===== src/falling_particle_grid_step_unit.sv =====
// write stores on acceptance, read captures memory data; each result is then registered
// init: per row, fills the inner-column order, then one generator step and remainder per swap
// step: frame 0 greys the borders first; one remainder per row and per multi-choice move;
//   the shared remainder unit and the single read port of the pixel memory pace init and step
// one command at a time; the next one is taken while a result waits at the output
// arst_n clears control, generator seed and registers; memories hold garbage until written
module falling_particle_grid_step_unit import fpgs_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [47:0]          s_tdata,   // command, column, row, data_value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // read_value, done_command
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int RB    = $clog2(MAX_HEIGHT);
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int AW    = CB + RB;
	localparam int DEPTH = 1 << AW;
	localparam int DIV_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

	typedef enum logic [24:0] {
		S_IDLE   = 25'h0000001,
		S_RD_W   = 25'h0000002,
		S_ADV    = 25'h0000004,
		S_ADV_W  = 25'h0000008,
		S_MOD_W  = 25'h0000010,
		S_I_FILL = 25'h0000020,
		S_I_SH   = 25'h0000040,
		S_I_RDI  = 25'h0000080,
		S_I_RDJ  = 25'h0000100,
		S_I_WRI  = 25'h0000200,
		S_I_WRJ  = 25'h0000400,
		S_B_L    = 25'h0000800,
		S_B_R    = 25'h0001000,
		S_ROW    = 25'h0002000,
		S_R_PROW = 25'h0004000,
		S_C_RDP  = 25'h0008000,
		S_C_COL  = 25'h0010000,
		S_C_CP   = 25'h0020000,
		S_C_D0   = 25'h0040000,
		S_C_D1   = 25'h0080000,
		S_C_D2   = 25'h0100000,
		S_C_PICK = 25'h0200000,
		S_C_MV   = 25'h0400000,
		S_C_CLR  = 25'h0800000,
		S_DONE   = 25'h1000000
	} state_t;

	state_t state_q, ret_q;

	logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
	logic [XW-1:0]    w_eff, c_eff;
	logic [YW-1:0]    h_eff;

	logic [CMD_W-1:0] cmd_q;
	logic [PIX_W-1:0] rv_q;
	logic [YW-1:0]    y_q, prow_q;
	logic [XW-1:0]    i_q, j_q, col_q;
	logic [PERM_W-1:0] pi_q;
	logic [PIX_W-1:0] cp_q;
	logic [2:0]       free_q;
	logic             multi_q;
	logic             mod_en_q, shift7_q;
	logic [DIV_W-1:0] div_q;
	logic             m_tvalid_q;
	logic [39:0]      m_tdata_q;

	logic [CMD_W-1:0] in_cmd;
	logic [POS_W-1:0] in_col, in_row;
	logic [PIX_W-1:0] in_data;
	logic             in_inside;
	logic             accept;

	logic              pix_we, perm_we;
	logic [AW-1:0]     pix_waddr, pix_raddr, perm_waddr, perm_raddr;
	logic [PIX_W-1:0]  pix_wdata, pix_rdata;
	logic [PERM_W-1:0] perm_wdata, perm_rdata;

	logic              lcg_load, lcg_go, lcg_busy;
	logic [SEED_W-1:0] lcg_load_value, seed;
	logic              mod_start, mod_busy;
	logic [SEED_W-1:0] mod_dividend;
	logic [DIV_W-1:0]  mod_rem;

	logic [31:0]       perm_col;
	logic [1:0]        free_cnt;
	logic [1:0]        pick, off_first, off_second, off;

	assign in_cmd  = s_tdata[1:0];
	assign in_col  = s_tdata[7:2];
	assign in_row  = s_tdata[13:8];
	assign in_data = s_tdata[45:14];
	assign in_inside = (32'(in_col) < 32'(MAX_WIDTH)) && (32'(in_row) < 32'(MAX_HEIGHT));
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// active size clamped to at least 3 wide and 2 high, and to what the store holds
	always_comb begin
		if (cfg_w_q < CFG_W'(3)) begin
			w_eff = XW'(3);
		end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(cfg_w_q);
		end
		if (cfg_h_q < CFG_W'(2)) begin
			h_eff = YW'(2);
		end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
			h_eff = YW'(MAX_HEIGHT);
		end else begin
			h_eff = YW'(cfg_h_q);
		end
		c_eff = w_eff - XW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_W'(64);
			cfg_h_q <= CFG_W'(64);
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) begin
				cfg_w_q <= cfg_data;
			end else if (cfg_index == REG_HEIGHT) begin
				cfg_h_q <= cfg_data;
			end
		end
	end

	assign perm_col = 32'(perm_rdata) + 32'd1;
	assign free_cnt = 2'(free_q[0]) + 2'(free_q[1]) + 2'(free_q[2]);
	assign pick     = multi_q ? mod_rem[1:0] : 2'd0;

	// pick-th free cell below, in left-to-right order
	always_comb begin
		off_first  = free_q[0] ? 2'd0 : (free_q[1] ? 2'd1 : 2'd2);
		off_second = (free_q[0] && free_q[1]) ? 2'd1 : 2'd2;
		case (pick)
			2'd0:    off = off_first;
			2'd1:    off = off_second;
			default: off = 2'd2;
		endcase
	end

	assign mod_dividend = shift7_q ? (seed >> PICK_SHIFT) : seed;
	assign lcg_load_value = {16'd0, in_data} ^ SEED_XOR;

	// memory ports and unit strobes
	always_comb begin
		pix_we     = 1'b0;
		pix_waddr  = '0;
		pix_wdata  = '0;
		pix_raddr  = '0;
		perm_we    = 1'b0;
		perm_waddr = '0;
		perm_wdata = '0;
		perm_raddr = '0;
		lcg_load   = 1'b0;
		lcg_go     = 1'b0;
		mod_start  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pix_waddr = {RB'(in_row), CB'(in_col)};
					pix_wdata = in_data;
					pix_raddr = {RB'(in_row), CB'(in_col)};
					pix_we    = (in_cmd == CMD_WRITE) && in_inside;
					lcg_load  = (in_cmd == CMD_INIT) || (in_cmd == CMD_STEP);
				end
			end
			S_ADV: lcg_go = 1'b1;
			S_ADV_W: mod_start = !lcg_busy && mod_en_q;
			S_I_FILL: begin
				perm_we    = 1'b1;
				perm_waddr = {y_q[RB-1:0], CB'(i_q + XW'(1))};
				perm_wdata = PERM_W'(i_q);
			end
			S_I_RDI: perm_raddr = {y_q[RB-1:0], CB'(i_q + XW'(1))};
			S_I_RDJ: perm_raddr = {y_q[RB-1:0], CB'(j_q + XW'(1))};
			S_I_WRI: begin
				perm_we    = 1'b1;
				perm_waddr = {y_q[RB-1:0], CB'(i_q + XW'(1))};
				perm_wdata = perm_rdata;
			end
			S_I_WRJ: begin
				perm_we    = 1'b1;
				perm_waddr = {y_q[RB-1:0], CB'(j_q + XW'(1))};
				perm_wdata = pi_q;
			end
			S_B_L: begin
				pix_we    = 1'b1;
				pix_waddr = {y_q[RB-1:0], CB'(0)};
				pix_wdata = BORDER_GREY;
			end
			S_B_R: begin
				pix_we    = 1'b1;
				pix_waddr = {y_q[RB-1:0], CB'(w_eff - XW'(1))};
				pix_wdata = BORDER_GREY;
			end
			S_C_RDP: perm_raddr = {prow_q[RB-1:0], CB'(i_q + XW'(1))};
			S_C_COL: pix_raddr = {RB'(y_q - YW'(1)), CB'(perm_col)};
			S_C_CP:  pix_raddr = {y_q[RB-1:0], CB'(col_q - XW'(1))};
			S_C_D0:  pix_raddr = {y_q[RB-1:0], CB'(col_q)};
			S_C_D1:  pix_raddr = {y_q[RB-1:0], CB'(col_q + XW'(1))};
			S_C_MV: begin
				pix_we    = 1'b1;
				pix_waddr = {y_q[RB-1:0], CB'(col_q - XW'(1) + XW'(off))};
				pix_wdata = cp_q;
			end
			S_C_CLR: begin
				pix_we    = 1'b1;
				pix_waddr = {RB'(y_q - YW'(1)), CB'(col_q)};
				pix_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			cmd_q      <= '0;
			rv_q       <= '0;
			y_q        <= '0;
			prow_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			col_q      <= '0;
			pi_q       <= '0;
			cp_q       <= '0;
			free_q     <= '0;
			multi_q    <= 1'b0;
			mod_en_q   <= 1'b0;
			shift7_q   <= 1'b0;
			div_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= in_cmd;
						rv_q  <= '0;
						i_q   <= '0;
						mod_en_q <= 1'b0;
						case (in_cmd)
							CMD_INIT: begin
								y_q     <= '0;
								ret_q   <= S_I_FILL;
								state_q <= S_ADV;
							end
							CMD_READ: state_q <= in_inside ? S_RD_W : S_DONE;
							CMD_STEP: begin
								y_q     <= (in_data == '0) ? YW'(0) : h_eff - YW'(1);
								ret_q   <= (in_data == '0) ? S_B_L : S_ROW;
								state_q <= S_ADV;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RD_W: begin
					rv_q    <= pix_rdata;
					state_q <= S_DONE;
				end
				S_ADV: state_q <= S_ADV_W;
				S_ADV_W: begin
					if (!lcg_busy) begin
						state_q <= mod_en_q ? S_MOD_W : ret_q;
					end
				end
				S_MOD_W: begin
					if (!mod_busy) begin
						state_q <= ret_q;
					end
				end
				S_I_FILL: begin
					if (i_q == c_eff - XW'(1)) begin
						i_q     <= '0;
						state_q <= S_I_SH;
					end else begin
						i_q <= i_q + XW'(1);
					end
				end
				S_I_SH: begin
					if (i_q + XW'(1) < c_eff) begin
						div_q    <= DIV_W'(c_eff - i_q);
						mod_en_q <= 1'b1;
						shift7_q <= 1'b0;
						ret_q    <= S_I_RDI;
						state_q  <= S_ADV;
					end else if (y_q == h_eff - YW'(1)) begin
						state_q <= S_DONE;
					end else begin
						y_q     <= y_q + YW'(1);
						i_q     <= '0;
						state_q <= S_I_FILL;
					end
				end
				S_I_RDI: begin
					j_q     <= i_q + XW'(mod_rem);
					state_q <= S_I_RDJ;
				end
				S_I_RDJ: begin
					pi_q    <= perm_rdata;
					state_q <= S_I_WRI;
				end
				S_I_WRI: state_q <= S_I_WRJ;
				S_I_WRJ: begin
					i_q     <= i_q + XW'(1);
					state_q <= S_I_SH;
				end
				S_B_L: state_q <= S_B_R;
				S_B_R: begin
					if (y_q == h_eff - YW'(1)) begin
						state_q <= S_ROW;
					end else begin
						y_q     <= y_q + YW'(1);
						state_q <= S_B_L;
					end
				end
				S_ROW: begin
					i_q      <= '0;
					div_q    <= DIV_W'(h_eff);
					mod_en_q <= 1'b1;
					shift7_q <= 1'b0;
					ret_q    <= S_R_PROW;
					state_q  <= S_ADV;
				end
				S_R_PROW: begin
					prow_q  <= YW'(mod_rem);
					state_q <= S_C_RDP;
				end
				S_C_RDP: begin
					if (i_q == c_eff) begin
						if (y_q == YW'(1)) begin
							state_q <= S_DONE;
						end else begin
							y_q     <= y_q - YW'(1);
							state_q <= S_ROW;
						end
					end else begin
						state_q <= S_C_COL;
					end
				end
				S_C_COL: begin
					// stale entry beyond the inner columns is skipped
					if (perm_col > 32'(c_eff)) begin
						i_q     <= i_q + XW'(1);
						state_q <= S_C_RDP;
					end else begin
						col_q   <= XW'(perm_col);
						state_q <= S_C_CP;
					end
				end
				S_C_CP: begin
					cp_q <= pix_rdata;
					if (pix_rdata == '0) begin
						i_q     <= i_q + XW'(1);
						state_q <= S_C_RDP;
					end else begin
						state_q <= S_C_D0;
					end
				end
				S_C_D0: begin
					free_q[0] <= (pix_rdata == '0);
					state_q   <= S_C_D1;
				end
				S_C_D1: begin
					free_q[1] <= (pix_rdata == '0);
					state_q   <= S_C_D2;
				end
				S_C_D2: begin
					free_q[2] <= (pix_rdata == '0);
					state_q   <= S_C_PICK;
				end
				S_C_PICK: begin
					multi_q <= (free_cnt > 2'd1);
					if (free_cnt == 2'd0) begin
						i_q     <= i_q + XW'(1);
						state_q <= S_C_RDP;
					end else if (free_cnt == 2'd1) begin
						state_q <= S_C_MV;
					end else begin
						div_q    <= DIV_W'(free_cnt);
						mod_en_q <= 1'b1;
						shift7_q <= 1'b1;
						ret_q    <= S_C_MV;
						state_q  <= S_ADV;
					end
				end
				S_C_MV: state_q <= S_C_CLR;
				S_C_CLR: begin
					i_q     <= i_q + XW'(1);
					state_q <= S_C_RDP;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, cmd_q, rv_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	fpgs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_pix_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (pix_wdata),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	fpgs_ram #(
		.WIDTH(PERM_W),
		.DEPTH(DEPTH)
	) u_perm_ram (
		.clk   (clk),
		.we    (perm_we),
		.waddr (perm_waddr),
		.wdata (perm_wdata),
		.raddr (perm_raddr),
		.rdata (perm_rdata)
	);

	fpgs_lcg u_lcg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (lcg_load),
		.load_value (lcg_load_value),
		.go         (lcg_go),
		.busy       (lcg_busy),
		.seed       (seed)
	);

	fpgs_mod #(
		.DIV_W(DIV_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (div_q),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	// generator and remainder unit never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(lcg_busy && mod_busy))
		else $error("generator and remainder unit busy together");

	a_mod_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mod_start |-> !mod_busy && !lcg_busy)
		else $error("remainder started while a unit is busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(lcg_busy || mod_busy) |-> !s_tready)
		else $error("input ready while a command is running");

endmodule

// ===== src/fpgs_ram.sv =====
module fpgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/fpgs_lcg.sv =====
module fpgs_lcg import fpgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [SEED_W-1:0] load_value,
	input  logic              go,
	output logic              busy,
	output logic [SEED_W-1:0] seed
);

	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] acc_q;
	logic [1:0]        step_q;
	logic              busy_q;
	logic [HALF_W-1:0] op_a;
	logic [HALF_W-1:0] op_b;
	logic [SEED_W-1:0] prod;
	logic [SEED_W-1:0] sum;

	// seed * mul mod 2^48 from three 24x24 partial products
	always_comb begin
		case (step_q)
			2'd0: begin
				op_a = seed_q[HALF_W-1:0];
				op_b = LCG_MUL_LO;
			end
			2'd1: begin
				op_a = seed_q[HALF_W-1:0];
				op_b = LCG_MUL_HI;
			end
			default: begin
				op_a = seed_q[SEED_W-1:HALF_W];
				op_b = LCG_MUL_LO;
			end
		endcase
		prod = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
		sum  = (step_q == 2'd0) ? prod : acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			acc_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (load) begin
			seed_q <= load_value;
		end else if (go) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
		end else if (busy_q) begin
			if (step_q == 2'd2) begin
				seed_q <= sum + LCG_ADD;
				busy_q <= 1'b0;
			end else begin
				acc_q  <= sum;
				step_q <= step_q + 2'd1;
			end
		end
	end

	assign busy = busy_q;
	assign seed = seed_q;

endmodule

// ===== src/fpgs_mod.sv =====
module fpgs_mod import fpgs_pkg::*; #(
	parameter int DIV_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SEED_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              busy,
	output logic [DIV_W-1:0]  rem
);

	localparam int CNT_W = $clog2(SEED_W);

	logic [SEED_W-1:0] num_q;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, num_q[SEED_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			num_q  <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(SEED_W - 1);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			rem_q <= (trial >= {1'b0, div_q}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			num_q <= {num_q[SEED_W-2:0], 1'b0};
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule
